>>> hdl/brb_pkg.sv
// Shared constants and types for the byte ring buffer.
`timescale 1ns / 1ps

package brb_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 13;
  localparam int DATA_W      = 8;
  localparam int CAP_RESET   = (STORE_DEPTH < 4096) ? STORE_DEPTH : 4096;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_PEEK  = 2'd1,
    ACT_SKIP  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

endpackage

>>> hdl/brb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/byte_ring_buffer_top.sv
// Top level of the byte ring buffer: control, pointers and the byte store.
//
// The input channel (in_valid, in_ready) carries one action per transaction:
// write a byte, peek at an offset from the oldest byte, skip a number of bytes,
// or read the oldest byte. Every input transaction yields exactly one output
// transaction (out_valid, out_ready) with the byte, the count done, and the
// fill level and free space after the action.
// A write, a skip or any refused action presents its result as it leaves the
// execute state; a peek or read that hits presents it as it leaves the fetch
// state that follows, which holds the registered read of the byte store. The
// block holds one action at a time and takes in no new one until it is done.
// An action is taken in while an earlier result still waits in the output
// register; it is executed once that register is free, so a stalled receiver
// holds back at most one further action.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) sets the capacity;
// it takes effect only when the buffer is empty and clears both pointers.
// Reset empties the buffer and sets the capacity to its default; the byte store
// itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module byte_ring_buffer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic [brb_pkg::DATA_W-1:0]          data_in,
  input  logic [brb_pkg::CNT_W-1:0]           amount,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [brb_pkg::DATA_W-1:0]          data_out,
  output logic [brb_pkg::CNT_W-1:0]           done_count,
  output logic [brb_pkg::CNT_W-1:0]           fill_level,
  output logic [brb_pkg::CNT_W-1:0]           free_space,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [brb_pkg::CNT_W-1:0]           cfg_data
);

  localparam int SUM_W = brb_pkg::CNT_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH
  } state_t;

  state_t                       state;
  brb_pkg::action_t             cmd_action;
  logic [brb_pkg::DATA_W-1:0]   cmd_data;
  logic [brb_pkg::CNT_W-1:0]    cmd_amount;
  logic [brb_pkg::CNT_W-1:0]    capacity;
  logic [brb_pkg::PTR_W-1:0]    wr_ptr;
  logic [brb_pkg::PTR_W-1:0]    rd_ptr;
  logic [brb_pkg::CNT_W-1:0]    fill;

  logic                         go;
  logic                         out_set;
  logic                         wr_ok;
  logic                         rd_ok;
  logic                         pk_ok;
  logic [brb_pkg::CNT_W-1:0]    skip_n;
  logic [brb_pkg::PTR_W-1:0]    ptr_in;
  logic [brb_pkg::CNT_W-1:0]    step;
  logic [SUM_W-1:0]             wrap_sum;
  logic [brb_pkg::PTR_W-1:0]    wrap_res;
  logic [brb_pkg::PTR_W-1:0]    wr_ptr_next;
  logic [brb_pkg::PTR_W-1:0]    rd_ptr_next;
  logic [brb_pkg::CNT_W-1:0]    fill_next;
  logic [brb_pkg::CNT_W-1:0]    done_next;
  logic                         fetch;
  logic [brb_pkg::CNT_W-1:0]    cap_sat;
  logic                         ram_we;
  logic                         ram_re;
  logic [brb_pkg::PTR_W-1:0]    ram_raddr;
  logic [brb_pkg::DATA_W-1:0]   ram_rdata;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign go        = (state == ST_EXEC) && (!out_valid || out_ready);
  assign out_set   = (go && !fetch) || (state == ST_FETCH);

  assign wr_ok  = (fill < capacity);
  assign rd_ok  = (fill != '0);
  assign pk_ok  = (cmd_amount < fill);
  assign skip_n = pk_ok ? cmd_amount : fill;

  always_comb begin
    ptr_in = rd_ptr;
    step   = brb_pkg::CNT_W'(1);
    case (cmd_action)
      brb_pkg::ACT_WRITE: ptr_in = wr_ptr;
      brb_pkg::ACT_PEEK:  step   = cmd_amount;
      brb_pkg::ACT_SKIP:  step   = skip_n;
      default:            step   = brb_pkg::CNT_W'(1);
    endcase
  end

  assign wrap_sum = SUM_W'(ptr_in) + SUM_W'(step);
  assign wrap_res = (wrap_sum >= SUM_W'(capacity)) ?
                    brb_pkg::PTR_W'(wrap_sum - SUM_W'(capacity)) :
                    brb_pkg::PTR_W'(wrap_sum);

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    fill_next   = fill;
    done_next   = '0;
    fetch       = 1'b0;
    unique case (cmd_action)
      brb_pkg::ACT_WRITE: begin
        if (wr_ok) begin
          wr_ptr_next = wrap_res;
          fill_next   = fill + brb_pkg::CNT_W'(1);
          done_next   = brb_pkg::CNT_W'(1);
        end
      end
      brb_pkg::ACT_PEEK: begin
        if (pk_ok) begin
          done_next = brb_pkg::CNT_W'(1);
          fetch     = 1'b1;
        end
      end
      brb_pkg::ACT_SKIP: begin
        if (skip_n != '0) begin
          rd_ptr_next = wrap_res;
          fill_next   = fill - skip_n;
          done_next   = skip_n;
        end
      end
      brb_pkg::ACT_READ: begin
        if (rd_ok) begin
          rd_ptr_next = wrap_res;
          fill_next   = fill - brb_pkg::CNT_W'(1);
          done_next   = brb_pkg::CNT_W'(1);
          fetch       = 1'b1;
        end
      end
      default: begin
        fetch = 1'b0;
      end
    endcase
  end

  assign ram_we    = go && (cmd_action == brb_pkg::ACT_WRITE) && wr_ok;
  assign ram_re    = go && fetch;
  assign ram_raddr = (cmd_action == brb_pkg::ACT_PEEK) ? wrap_res : rd_ptr;

  assign cap_sat = (cfg_data > brb_pkg::CNT_W'(brb_pkg::STORE_DEPTH)) ?
                   brb_pkg::CNT_W'(brb_pkg::STORE_DEPTH) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      capacity  <= brb_pkg::CNT_W'(brb_pkg::CAP_RESET);
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      fill      <= '0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid && cfg_data != '0 && fill == '0) begin
            capacity <= cap_sat;
            wr_ptr   <= '0;
            rd_ptr   <= '0;
          end
          if (in_valid) begin
            cmd_action <= brb_pkg::action_t'(action);
            cmd_data   <= data_in;
            cmd_amount <= amount;
            state      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (go) begin
            wr_ptr     <= wr_ptr_next;
            rd_ptr     <= rd_ptr_next;
            fill       <= fill_next;
            done_count <= done_next;
            fill_level <= fill_next;
            free_space <= capacity - fill_next;
            data_out   <= '0;
            if (fetch) begin
              state <= ST_FETCH;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_FETCH: begin
          data_out <= ram_rdata;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  brb_ram #(
    .WIDTH (brb_pkg::DATA_W),
    .DEPTH (brb_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (cmd_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> hdl/brb_checker.sv
// Port-level assertions for the byte ring buffer and their binding.
`timescale 1ns / 1ps

module brb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [brb_pkg::DATA_W-1:0] data_out,
  input logic [brb_pkg::CNT_W-1:0]  done_count,
  input logic [brb_pkg::CNT_W-1:0]  fill_level,
  input logic [brb_pkg::CNT_W-1:0]  free_space,
  input logic                       cfg_ready
);

  localparam int SUM_W = brb_pkg::CNT_W + 1;

  // A waiting result keeps its contents until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out) &&
      $stable(done_count) && $stable(fill_level) && $stable(free_space))
    else $error("Output changed while stalled.");

  // The buffer works on one action at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !cfg_ready)
    else $error("Second action accepted while one is in progress.");

  // A refused action, one with a zero count done, returns a zero byte.
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_count == '0 |-> data_out == '0)
    else $error("Nonzero byte on a refused action.");

  // Fill level plus free space, the capacity, is checked never to exceed the store depth.
  a_levels: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (SUM_W'(fill_level) + SUM_W'(free_space)) <=
      SUM_W'(brb_pkg::STORE_DEPTH) && done_count <= fill_level + done_count)
    else $error("Fill level and free space exceed the store depth.");

endmodule

bind byte_ring_buffer_top brb_checker u_brb_checker (.*);
